[sv/fce_pkg.sv]
// Shared types, opcodes and the Fibonacci weight table of the Fibonacci code encoder.
`default_nettype none

package fce_pkg;

    // Opcode carried in the input beat's tuser.
    localparam logic OP_ENCODE = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef logic [21:0] t_value;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new input beat
        logic step;    // one greedy Zeckendorf step
        logic pack;    // merge pending bits and code into the byte stream
        logic emit;    // send the next byte of the stream
        logic commit;  // keep the leftover bits as pending
        logic flush;   // send the padded partial byte
        logic bad;     // send an error beat
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_flush;
        logic is_bad;
        logic pend_empty;
        logic k_zero;
        logic nb_zero;
        logic out_free;
    } t_dp_sts;

    // Fibonacci weights 1, 2, 3, 5, 8, ...
    function automatic t_value fib_weight(input logic [4:0] idx);
        t_value w;
        case (idx)
            5'd0:    w = 22'd1;
            5'd1:    w = 22'd2;
            5'd2:    w = 22'd3;
            5'd3:    w = 22'd5;
            5'd4:    w = 22'd8;
            5'd5:    w = 22'd13;
            5'd6:    w = 22'd21;
            5'd7:    w = 22'd34;
            5'd8:    w = 22'd55;
            5'd9:    w = 22'd89;
            5'd10:   w = 22'd144;
            5'd11:   w = 22'd233;
            5'd12:   w = 22'd377;
            5'd13:   w = 22'd610;
            5'd14:   w = 22'd987;
            5'd15:   w = 22'd1597;
            5'd16:   w = 22'd2584;
            5'd17:   w = 22'd4181;
            5'd18:   w = 22'd6765;
            5'd19:   w = 22'd10946;
            5'd20:   w = 22'd17711;
            5'd21:   w = 22'd28657;
            5'd22:   w = 22'd46368;
            5'd23:   w = 22'd75025;
            5'd24:   w = 22'd121393;
            5'd25:   w = 22'd196418;
            5'd26:   w = 22'd317811;
            5'd27:   w = 22'd514229;
            5'd28:   w = 22'd832040;
            5'd29:   w = 22'd1346269;
            5'd30:   w = 22'd2178309;
            5'd31:   w = 22'd3524578;
            default: w = 22'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[sv/fce_datapath.sv]
// Datapath of the Fibonacci code encoder: greedy digit unit, bit packer and output register.
`default_nettype none

module fce_datapath import fce_pkg::*; #(
    parameter int MAX_CODE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_dp_cmd     i_cmd,
    output t_dp_sts          o_sts,
    input  wire logic        i_opcode,
    input  wire t_value      i_value,
    input  wire logic        i_out_ready,
    output logic             o_out_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_out_bad,
    output logic             o_out_last
);

    localparam int KW    = $clog2(MAX_CODE_BITS);
    localparam int SW    = MAX_CODE_BITS + 8;
    localparam int LW    = $clog2(SW);
    localparam int NBMAX = (MAX_CODE_BITS + 7) / 8;
    localparam int NBW   = $clog2(NBMAX + 1);
    localparam logic [KW-1:0] K_START = KW'(MAX_CODE_BITS - 2);
    localparam t_value LIMIT = fib_weight(5'(MAX_CODE_BITS - 1));

    logic                     r_op;
    t_value                   r_rem;
    logic [KW-1:0]            r_k;
    logic [KW-1:0]            r_top;
    logic                     r_found;
    logic [MAX_CODE_BITS-2:0] r_digits;
    logic [SW-1:0]            r_stream;
    logic [NBW-1:0]           r_nb;
    logic [2:0]               r_lrem;
    logic [6:0]               r_pend_la;
    logic [2:0]               r_pend_cnt;
    logic                     r_out_valid;
    logic [7:0]               r_out_byte;
    logic                     r_out_bad;
    logic                     r_out_last;

    t_value                   w_weight;
    logic                     w_take;
    logic [KW-1:0]            w_top1;
    logic [MAX_CODE_BITS-1:0] w_code;
    logic [SW-1:0]            w_stream;
    logic [LW-1:0]            w_len;
    logic                     w_out_free;

    assign w_weight   = fib_weight(5'(r_k));
    assign w_take     = (w_weight <= r_rem);
    assign w_top1     = r_top + 1'b1;
    assign w_out_free = !r_out_valid || i_out_ready;

    // Code left aligned: lowest-weight digit first, then the terminating 1.
    always_comb begin
        w_code = '0;
        for (int i = 0; i < MAX_CODE_BITS - 1; i++) begin
            w_code[MAX_CODE_BITS-1-i] = r_digits[i];
        end
        for (int j = 0; j < MAX_CODE_BITS; j++) begin
            if (w_top1 == KW'(j)) begin
                w_code[MAX_CODE_BITS-1-j] = 1'b1;
            end
        end
    end

    assign w_stream = {r_pend_la, (SW-7)'(0)} | ({w_code, 8'h00} >> r_pend_cnt);
    assign w_len    = LW'(r_pend_cnt) + LW'(r_top) + LW'(2);

    always_comb begin
        o_sts.is_flush   = (r_op == OP_FLUSH);
        o_sts.is_bad     = (r_rem == '0) || (r_rem >= LIMIT);
        o_sts.pend_empty = (r_pend_cnt == 3'd0);
        o_sts.k_zero     = (r_k == '0);
        o_sts.nb_zero    = (r_nb == '0);
        o_sts.out_free   = w_out_free;
    end

    // Greedy Zeckendorf unit, one weight per cycle from the top down.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= i_opcode;
            r_rem    <= i_value;
            r_k      <= K_START;
            r_found  <= 1'b0;
            r_digits <= '0;
        end else if (i_cmd.step) begin
            if (w_take) begin
                r_rem         <= r_rem - w_weight;
                r_digits[r_k] <= 1'b1;
                if (!r_found) begin
                    r_top   <= r_k;
                    r_found <= 1'b1;
                end
            end
            r_k <= r_k - 1'b1;
        end
    end

    // Byte stream and its counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nb <= '0;
        end else if (i_cmd.pack) begin
            r_stream <= w_stream;
            r_nb     <= NBW'(w_len >> 3);
            r_lrem   <= w_len[2:0];
        end else if (i_cmd.emit) begin
            r_stream <= r_stream << 8;
            r_nb     <= r_nb - 1'b1;
        end
    end

    // Pending bits, kept left aligned.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_la  <= '0;
            r_pend_cnt <= '0;
        end else if (i_cmd.commit) begin
            r_pend_la  <= r_stream[SW-1 -: 7];
            r_pend_cnt <= r_lrem;
        end else if (i_cmd.flush) begin
            r_pend_la  <= '0;
            r_pend_cnt <= '0;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.flush || i_cmd.bad) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_byte <= r_stream[SW-1 -: 8];
            r_out_bad  <= 1'b0;
            r_out_last <= (r_nb == NBW'(1));
        end else if (i_cmd.flush) begin
            r_out_byte <= {r_pend_la, 1'b0};
            r_out_bad  <= 1'b0;
            r_out_last <= 1'b1;
        end else if (i_cmd.bad) begin
            r_out_byte <= 8'h00;
            r_out_bad  <= 1'b1;
            r_out_last <= 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_bad   = r_out_bad;
    assign o_out_last  = r_out_last;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit || i_cmd.flush || i_cmd.bad) |-> w_out_free)
        else $error("beat loaded into a busy output register");

    a_commit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit |-> (r_nb == '0))
        else $error("pending bits committed before all bytes were sent");

    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> (r_pend_cnt == 3'd0))
        else $error("flush left pending bits");

    a_nb_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pack |=> (r_nb <= NBW'(NBMAX)))
        else $error("byte count above the largest possible");

endmodule

`default_nettype wire

[sv/fce_ctrl.sv]
// Controller state machine of the Fibonacci code encoder.
`default_nettype none

module fce_ctrl import fce_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_CONV = 3'd2;
    localparam logic [2:0] S_PACK = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                if (i_sts.is_flush) begin
                    if (i_sts.pend_empty) begin
                        n_state = S_IDLE;
                    end else if (i_sts.out_free) begin
                        o_cmd.flush = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (i_sts.is_bad) begin
                    if (i_sts.out_free) begin
                        o_cmd.bad = 1'b1;
                        n_state   = S_IDLE;
                    end
                end else begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                if (i_sts.k_zero) begin
                    n_state = S_PACK;
                end
            end
            S_PACK: begin
                o_cmd.pack = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.nb_zero) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[sv/fibonacci_code_encoder.sv]
// Top level of the Fibonacci code encoder: stream ports, controller and datapath.
// An encode beat occupies the block from acceptance until the 0 to 4 bytes it completes have
// been handed to the output register; the greedy digit unit tries one Fibonacci weight per cycle
// from the top down, and each byte waits while the output register is still full.
// A flush or an out-of-range value needs only the dispatch state; each output beat is
// registered and may wait in the output register while the next beat enters.
// Synchronous active-low reset clears the pending bits, the state machine and the output valid.
`default_nettype none

module fibonacci_code_encoder import fce_pkg::*; #(
    parameter int MAX_CODE_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [21:0] value, [23:22] zero
    input  wire logic [0:0]  s_axis_tuser,   // [0] opcode
    // Output stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic [0:0]       m_axis_tuser,   // [0] bad_value
    output logic             m_axis_tlast    // is_last
);

    // Commands and status between the controller and the datapath.
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_out_bad;

    // The controller takes one input beat at a time, sequences the greedy conversion, the packing
    // step and the byte beats, or the flush or error beat, then returns to idle.
    fce_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the digit unit, the pending bits and the output register.
    fce_datapath #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_opcode    (s_axis_tuser[0]),
        .i_value     (s_axis_tdata[21:0]),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_byte  (m_axis_tdata),
        .o_out_bad   (w_out_bad),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tuser = w_out_bad;

endmodule

`default_nettype wire

[tb/testbench.sv]
// Self-checking testbench for the Fibonacci code encoder, with directed and random beats.
`timescale 1ns / 1ps

module testbench;
    import fce_pkg::*;

    // One output beat as the encoder should send it.
    typedef struct packed {
        logic [7:0] code_byte;
        logic       bad;
        logic       last;
    } t_code_beat;

    // One row of the directed table. Where typed is set, the expected beats are
    // written into the row, otherwise they come from the code predictor.
    typedef struct packed {
        logic        op;
        logic [21:0] value;
        logic        typed;
        logic [1:0]  typed_n;
        t_code_beat  typed_beat;
    } t_dir_row;

    localparam int N_DIR     = 23;
    localparam int HOLD_LONG = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [21:0] value, [23:22] zero
    logic [0:0]  s_axis_tuser = '0;   // [0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;        // [7:0] out_byte
    logic [0:0]  m_axis_tuser;        // [0] bad_value
    logic        m_axis_tlast;        // is_last

    fibonacci_code_encoder u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // The 12 ns clock: high half, then low half.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Predictor state: Fibonacci weights, the pending bits not yet sent (earliest bit
    // highest) and how many of them are valid.
    int unsigned fib_w [0:31];
    logic [6:0]  pend_bits = '0;
    logic [2:0]  pend_cnt = '0;
    t_code_beat  step_beats [0:3];
    t_code_beat  beats_due [$];

    int   mismatch_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_taken = 1'b0;
    int   hold_left = 0;

    t_dir_row dir_rows [0:N_DIR-1];

    function automatic t_code_beat make_beat(input logic [7:0] b, input logic bad,
                                             input logic last);
        t_code_beat r;
        r.code_byte = b;
        r.bad = bad;
        r.last = last;
        return r;
    endfunction

    function automatic t_dir_row dir_row(input logic op, input logic [21:0] v,
                                         input logic typed, input logic [1:0] n,
                                         input logic [7:0] b, input logic bad);
        t_dir_row r;
        r.op = op;
        r.value = v;
        r.typed = typed;
        r.typed_n = n;
        r.typed_beat = make_beat(b, bad, 1'b1);
        return r;
    endfunction

    // Works out the beats that one accepted input beat causes, leaves them in
    // step_beats and returns how many there are. Updates the pending bits.
    function automatic int fib_code_step(input logic op, input logic [21:0] v);
        logic [7:0]  acc;
        logic [31:0] digits;
        int unsigned rem;
        int          cnt;
        int          top;
        int          n;
        int          k;
        n = 0;
        if (op == OP_FLUSH) begin
            // A flush with nothing pending sends nothing.
            if (pend_cnt == 3'd0) begin
                return 0;
            end
            acc = {1'b0, pend_bits} << (8 - pend_cnt);
            step_beats[0] = make_beat(acc, 1'b0, 1'b1);
            pend_bits = '0;
            pend_cnt = '0;
            return 1;
        end
        // Zero, or a value whose code would not fit in 32 bits, is refused with
        // one error beat and leaves the pending bits alone.
        if (v == 22'd0 || v >= fib_w[31]) begin
            step_beats[0] = make_beat(8'h00, 1'b1, 1'b1);
            return 1;
        end
        top = 0;
        while (top < 31 && fib_w[top + 1] <= v) begin
            top++;
        end
        // Greedy Zeckendorf digits, highest weight first.
        digits = '0;
        rem = v;
        for (k = top; k >= 0; k--) begin
            if (fib_w[k] <= rem) begin
                digits[k] = 1'b1;
                rem -= fib_w[k];
            end
        end
        // The digits go out lowest weight first, then the closing 1.
        acc = {1'b0, pend_bits};
        cnt = pend_cnt;
        for (k = 0; k <= top + 1; k++) begin
            acc = {acc[6:0], (k <= top) ? digits[k] : 1'b1};
            cnt++;
            if (cnt == 8) begin
                if (n < 4) begin
                    step_beats[n] = make_beat(acc, 1'b0, 1'b0);
                end
                n++;
                acc = '0;
                cnt = 0;
            end
        end
        if (n > 4) begin
            n = 4;
        end
        if (n > 0) begin
            step_beats[n - 1] = make_beat(step_beats[n - 1].code_byte, 1'b0, 1'b1);
        end
        pend_bits = acc[6:0];
        pend_cnt = cnt[2:0];
        return n;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        if (mismatch_count <= 40) begin
            $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
        end
    endtask

    // Offers one beat to the encoder, waits for it to be taken and then files the
    // beats it should cause. A typed row overrides the predictor's beats, but the
    // predictor still runs so that its pending bits stay in step.
    task automatic offer_item(input logic op, input logic [21:0] v, input logic typed,
                              input int typed_n, input t_code_beat typed_beat);
        int n;
        int k;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, v};
        s_axis_tuser  <= op;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        n = fib_code_step(op, v);
        if (typed) begin
            n = typed_n;
            step_beats[0] = typed_beat;
        end
        for (k = 0; k < n; k++) begin
            beats_due.push_back(step_beats[k]);
        end
    endtask

    // Random input beat: mostly valid encodes of every size, some refused values
    // and some flushes.
    task automatic offer_random;
        int          pick;
        int          w;
        logic [21:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 14) begin
            offer_item(OP_FLUSH, 22'($urandom_range(0, 4194303)), 1'b0, 0, '0);
        end else if (pick < 22) begin
            if ($urandom_range(0, 2) == 0) begin
                v = 22'd0;
            end else begin
                v = 22'($urandom_range(3524578, 4194303));
            end
            offer_item(OP_ENCODE, v, 1'b0, 0, '0);
        end else begin
            w = $urandom_range(1, 22);
            v = 22'($urandom & ((32'd1 << w) - 1));
            if (v == 22'd0) begin
                v = 22'd1;
            end
            if (v >= 22'd3524578) begin
                v = v - 22'd3524577;
            end
            offer_item(OP_ENCODE, v, 1'b0, 0, '0);
        end
    endtask

    // Receiver side: random stalls, plus one long hold-off on request so that
    // the encoder fills up and has to refuse input beats.
    always @(posedge i_clk) begin
        if (hold_go && !hold_taken) begin
            hold_taken    <= 1'b1;
            hold_left     <= HOLD_LONG;
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Every beat the encoder sends is checked against the oldest expected beat.
    always @(posedge i_clk) begin : watch_output
        t_code_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (beats_due.size() == 0) begin
                note_mismatch("output beat with none expected", m_axis_tdata, 0);
            end else begin
                want = beats_due.pop_front();
                if (m_axis_tdata !== want.code_byte) begin
                    note_mismatch("out_byte", m_axis_tdata, want.code_byte);
                end
                if (m_axis_tuser[0] !== want.bad) begin
                    note_mismatch("bad_value", m_axis_tuser[0], want.bad);
                end
                if (m_axis_tlast !== want.last) begin
                    note_mismatch("is_last", m_axis_tlast, want.last);
                end
            end
        end
    end

    // Overall limit on the run, several times the slowest correct run.
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int k;
        fib_w[0] = 1;
        fib_w[1] = 2;
        for (k = 2; k < 32; k++) begin
            fib_w[k] = fib_w[k - 1] + fib_w[k - 2];
        end

        // Directed table. The typed rows are the plain cases: nothing sent after
        // reset, refused values, and the code of 1 (two ones) flushed alone.
        dir_rows[0]  = dir_row(OP_FLUSH,  22'd0,       1'b1, 2'd0, 8'h00, 1'b0);
        dir_rows[1]  = dir_row(OP_ENCODE, 22'd0,       1'b1, 2'd1, 8'h00, 1'b1);
        dir_rows[2]  = dir_row(OP_ENCODE, 22'd3524578, 1'b1, 2'd1, 8'h00, 1'b1);
        dir_rows[3]  = dir_row(OP_ENCODE, 22'h3FFFFF,  1'b1, 2'd1, 8'h00, 1'b1);
        dir_rows[4]  = dir_row(OP_ENCODE, 22'd1,       1'b1, 2'd0, 8'h00, 1'b0);
        dir_rows[5]  = dir_row(OP_FLUSH,  22'h3FFFFF,  1'b1, 2'd1, 8'hC0, 1'b0);
        dir_rows[6]  = dir_row(OP_ENCODE, 22'd3524577, 1'b0, 2'd0, 8'h00, 1'b0);
        dir_rows[7]  = dir_row(OP_ENCODE, 22'd2178309, 1'b0, 2'd0, 8'h00, 1'b0);
        dir_rows[8]  = dir_row(OP_ENCODE, 22'd0,       1'b1, 2'd1, 8'h00, 1'b1);
        dir_rows[9]  = dir_row(OP_FLUSH,  22'd0,       1'b0, 2'd0, 8'h00, 1'b0);
        dir_rows[10] = dir_row(OP_FLUSH,  22'd5,       1'b1, 2'd0, 8'h00, 1'b0);
        dir_rows[11] = dir_row(OP_ENCODE, 22'd2,       1'b0, 2'd0, 8'h00, 1'b0);
        dir_rows[12] = dir_row(OP_ENCODE, 22'd3,       1'b0, 2'd0, 8'h00, 1'b0);
        dir_rows[13] = dir_row(OP_ENCODE, 22'd4,       1'b0, 2'd0, 8'h00, 1'b0);
        dir_rows[14] = dir_row(OP_ENCODE, 22'h2AAAAA,  1'b0, 2'd0, 8'h00, 1'b0);
        dir_rows[15] = dir_row(OP_ENCODE, 22'h155555,  1'b0, 2'd0, 8'h00, 1'b0);
        dir_rows[16] = dir_row(OP_ENCODE, 22'h200000,  1'b0, 2'd0, 8'h00, 1'b0);
        dir_rows[17] = dir_row(OP_ENCODE, 22'd1,       1'b0, 2'd0, 8'h00, 1'b0);
        dir_rows[18] = dir_row(OP_ENCODE, 22'd1,       1'b0, 2'd0, 8'h00, 1'b0);
        dir_rows[19] = dir_row(OP_ENCODE, 22'd1,       1'b0, 2'd0, 8'h00, 1'b0);
        dir_rows[20] = dir_row(OP_ENCODE, 22'd1,       1'b0, 2'd0, 8'h00, 1'b0);
        dir_rows[21] = dir_row(OP_ENCODE, 22'h3FFFFE,  1'b1, 2'd1, 8'h00, 1'b1);
        dir_rows[22] = dir_row(OP_FLUSH,  22'd0,       1'b0, 2'd0, 8'h00, 1'b0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with no idling on either side.
        for (k = 0; k < N_DIR; k++) begin
            offer_item(dir_rows[k].op, dir_rows[k].value, dir_rows[k].typed,
                       dir_rows[k].typed_n, dir_rows[k].typed_beat);
        end

        // Back-pressure: the receiver holds off for a long stretch while the
        // sender keeps offering beats, so the encoder fills and stalls.
        hold_go <= 1'b1;
        for (k = 0; k < 20; k++) offer_random();

        // Random phases: no idling, then an idle sender, a stalling receiver,
        // and finally light idling on both sides.
        for (k = 0; k < 60; k++) offer_random();
        send_idle_pct = 84;
        for (k = 0; k < 60; k++) offer_random();
        send_idle_pct = 0;
        recv_stall_pct = 84;
        for (k = 0; k < 60; k++) offer_random();
        send_idle_pct = 18;
        recv_stall_pct = 18;
        for (k = 0; k < 107; k++) offer_random();

        s_axis_tvalid <= 1'b0;
        while (beats_due.size() != 0) begin
            @(posedge i_clk);
        end
        // Let a stray late beat show itself before the verdict.
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
